>>> hdl/playfair_digraph_encrypt_macros.svh
// ---------------------------------------------------------------------------
// Playfair digraph encryptor: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define PFE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PFE_ASSERT_IMPL(lbl, ante, cons, msg)
`define PFE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/pfe_pkg.sv
// ---------------------------------------------------------------------------
// pfe_pkg
// Shared constants, types and helpers of the Playfair digraph encryptor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int SIDE      = 5;
    localparam int CODE_W    = 5;
    localparam int IDX_W     = 3;
    localparam int CHAR_W    = 8;
    localparam int CIPHER_W  = 7;
    localparam int ROW_W     = SIDE * CODE_W;
    localparam int CFG_IDX_W = 3;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SIDE-1:0][SIDE-1:0][CODE_W-1:0] t_key_sq;

    typedef struct packed {
        t_idx row;
        t_idx col;
    } t_loc;

    // Letter codes, A = 0
    localparam t_code CODE_I = 5'd8;
    localparam t_code CODE_J = 5'd9;
    localparam t_code CODE_X = 5'd23;

    // ASCII ranges
    localparam logic [CHAR_W-1:0] ASCII_UC_A = 8'd65;
    localparam logic [CHAR_W-1:0] ASCII_UC_Z = 8'd90;
    localparam logic [CHAR_W-1:0] ASCII_LC_A = 8'd97;
    localparam logic [CHAR_W-1:0] ASCII_LC_Z = 8'd122;
    localparam logic [CIPHER_W-1:0] CIPHER_BASE = 7'd65;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW4 = 3'd4;

    // Reset square: MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC (row 0 lowest)
    localparam t_key_sq KEY_RESET = t_key_sq'({
        25'd2149955, 25'd6848868, 25'd25942713, 25'd17283508, 25'd10755244
    });

    // Step a row or column index by one, wrapping at the square side
    function automatic t_idx wrap_inc(input t_idx idx);
        t_idx res;
        if (idx == t_idx'(SIDE - 1)) begin
            res = '0;
        end else begin
            res = idx + t_idx'(1);
        end
        return res;
    endfunction

    // Letter code to uppercase ASCII, kept to seven bits
    function automatic logic [CIPHER_W-1:0] to_ascii(input t_code code);
        return CIPHER_BASE + {{(CIPHER_W-CODE_W){1'b0}}, code};
    endfunction

endpackage

>>> hdl/pfe_locate.sv
// ---------------------------------------------------------------------------
// pfe_locate
// Find a letter code in the key square; first match in row-major order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_locate (
    input  pfe_pkg::t_key_sq i_key,
    input  pfe_pkg::t_code   i_code,
    output pfe_pkg::t_loc    o_loc
);

    logic [pfe_pkg::SIDE-1:0][pfe_pkg::SIDE-1:0] hit;
    logic is_j;

    assign is_j = (i_code == pfe_pkg::CODE_J);

    // One comparator per cell
    always_comb begin
        for (int r = 0; r < pfe_pkg::SIDE; r++) begin
            for (int c = 0; c < pfe_pkg::SIDE; c++) begin
                hit[r][c] = (i_key[r][c] == i_code) ||
                            (is_j && (i_key[r][c] == pfe_pkg::CODE_I));
            end
        end
    end

    // Priority pick: scan from the last cell back so the earliest hit wins;
    // no hit leaves row 0, column 0
    always_comb begin
        o_loc = '0;
        for (int r = pfe_pkg::SIDE - 1; r >= 0; r--) begin
            for (int c = pfe_pkg::SIDE - 1; c >= 0; c--) begin
                if (hit[r][c]) begin
                    o_loc.row = pfe_pkg::t_idx'(r);
                    o_loc.col = pfe_pkg::t_idx'(c);
                end
            end
        end
    end

endmodule

>>> hdl/pfe_cipher.sv
// ---------------------------------------------------------------------------
// pfe_cipher
// Encrypt one digraph against the key square (row, column, rectangle rules).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_cipher (
    input  pfe_pkg::t_key_sq i_key,
    input  pfe_pkg::t_code   i_first,
    input  pfe_pkg::t_code   i_second,
    output pfe_pkg::t_code   o_first,
    output pfe_pkg::t_code   o_second
);

    pfe_pkg::t_loc loc1;
    pfe_pkg::t_loc loc2;

    pfe_locate u_loc1 (
        .i_key  (i_key),
        .i_code (i_first),
        .o_loc  (loc1)
    );

    pfe_locate u_loc2 (
        .i_key  (i_key),
        .i_code (i_second),
        .o_loc  (loc2)
    );

    always_comb begin
        if (loc1.row == loc2.row) begin
            // same row: take the letter to the right
            o_first  = i_key[loc1.row][pfe_pkg::wrap_inc(loc1.col)];
            o_second = i_key[loc2.row][pfe_pkg::wrap_inc(loc2.col)];
        end else if (loc1.col == loc2.col) begin
            // same column: take the letter below
            o_first  = i_key[pfe_pkg::wrap_inc(loc1.row)][loc1.col];
            o_second = i_key[pfe_pkg::wrap_inc(loc2.row)][loc2.col];
        end else begin
            // rectangle: swap columns, keep rows
            o_first  = i_key[loc1.row][loc2.col];
            o_second = i_key[loc2.row][loc1.col];
        end
    end

endmodule

>>> hdl/playfair_digraph_encrypt.sv
// ---------------------------------------------------------------------------
// playfair_digraph_encrypt: Playfair digraph encryptor, configurable 5x5 key
// Pipeline: the item is registered in stage A, the encrypted pair in stage B; first letter out, then second.
// Throughput: one item in, one letter out per cycle unless stalled; a new pair waits in stage A until stage B frees.
// Reset: synchronous, active low; clears pending letter and valids, restores the key square.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "playfair_digraph_encrypt_macros.svh"

module playfair_digraph_encrypt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pfe_pkg::CHAR_W-1:0]         i_in_char,
    input  logic                               i_message_end,
    // result item channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pfe_pkg::CIPHER_W-1:0]       o_cipher_char,
    output logic                               o_last_of_run,
    output logic                               o_message_done,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfe_pkg::ROW_W-1:0]          i_cfg_data
);

    // ------------------------------------------------------------------
    // Key square registers
    // ------------------------------------------------------------------
    pfe_pkg::t_key_sq r_key;

    // Writes are taken at any time; the host must write only while idle; the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= pfe_pkg::KEY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pfe_pkg::CFG_KEY_ROW0: r_key[0] <= i_cfg_data;
                pfe_pkg::CFG_KEY_ROW1: r_key[1] <= i_cfg_data;
                pfe_pkg::CFG_KEY_ROW2: r_key[2] <= i_cfg_data;
                pfe_pkg::CFG_KEY_ROW3: r_key[3] <= i_cfg_data;
                pfe_pkg::CFG_KEY_ROW4: r_key[4] <= i_cfg_data;
                default: ; // drop writes past the last row
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register (stage A)
    // ------------------------------------------------------------------
    logic                          r_a_valid;
    logic [pfe_pkg::CHAR_W-1:0]    r_a_char;
    logic                          r_a_end;

    // Pending first letter of a pair
    logic                          r_pend_valid;
    pfe_pkg::t_code                r_pend_code;

    // Pair register (stage B), drained one letter per cycle when the output is not stalled
    logic                          r_b_valid;
    logic                          r_b_half;
    logic [pfe_pkg::CIPHER_W-1:0]  r_b_c1;
    logic [pfe_pkg::CIPHER_W-1:0]  r_b_c2;
    logic                          r_b_done;

    logic                          in_accept;
    logic                          a_move;
    logic                          a_pair;
    logic                          b_free;
    logic                          b_load;
    logic                          out_accept;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_char <= i_in_char;
            r_a_end  <= i_message_end;
        end
    end

    // ------------------------------------------------------------------
    // Decode the held character and decide on a pair
    // ------------------------------------------------------------------
    logic            is_letter;
    pfe_pkg::t_code  a_code;
    pfe_pkg::t_code  pair_first;
    pfe_pkg::t_code  pair_second;
    logic            pair_done;
    logic            n_pend_valid;
    pfe_pkg::t_code  n_pend_code;

    always_comb begin
        is_letter = 1'b0;
        a_code    = '0;
        case (r_a_char) inside
            [pfe_pkg::ASCII_UC_A:pfe_pkg::ASCII_UC_Z]: begin
                is_letter = 1'b1;
                a_code    = pfe_pkg::t_code'(r_a_char - pfe_pkg::ASCII_UC_A);
            end
            [pfe_pkg::ASCII_LC_A:pfe_pkg::ASCII_LC_Z]: begin
                is_letter = 1'b1;
                a_code    = pfe_pkg::t_code'(r_a_char - pfe_pkg::ASCII_LC_A);
            end
            default: ; // skip non-letters
        endcase
    end

    always_comb begin
        a_pair       = 1'b0;
        pair_first   = r_pend_code;
        pair_second  = pfe_pkg::CODE_X;
        pair_done    = 1'b1;
        n_pend_valid = r_pend_valid;
        n_pend_code  = r_pend_code;
        if (is_letter) begin
            if (r_pend_valid) begin
                // complete the waiting pair
                a_pair       = 1'b1;
                pair_second  = a_code;
                pair_done    = r_a_end;
                n_pend_valid = 1'b0;
                n_pend_code  = '0;
            end else if (r_a_end) begin
                // lone final letter: pad with X
                a_pair     = 1'b1;
                pair_first = a_code;
            end else begin
                // hold as first letter
                n_pend_valid = 1'b1;
                n_pend_code  = a_code;
            end
        end else if (r_a_end && r_pend_valid) begin
            // message ends on a non-letter: pad the waiting letter
            a_pair = 1'b1;
        end
        if (r_a_end) begin
            n_pend_valid = 1'b0;
            n_pend_code  = '0;
        end
    end

    // ------------------------------------------------------------------
    // Encrypt the pair
    // ------------------------------------------------------------------
    pfe_pkg::t_code enc_first;
    pfe_pkg::t_code enc_second;

    pfe_cipher u_cipher (
        .i_key    (r_key),
        .i_first  (pair_first),
        .i_second (pair_second),
        .o_first  (enc_first),
        .o_second (enc_second)
    );

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    // Pair register is free when empty, or once its second letter leaves
    assign b_free     = !r_b_valid || (r_b_half && !i_out_stall);
    assign a_move     = r_a_valid && (!a_pair || b_free);
    assign b_load     = a_move && a_pair;
    assign o_in_stall = r_a_valid && !a_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_code  <= '0;
        end else if (a_move) begin
            r_pend_valid <= n_pend_valid;
            r_pend_code  <= n_pend_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_half  <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= 1'b1;
            r_b_half  <= 1'b0;
        end else if (out_accept) begin
            // advance to the second letter, then drop the pair
            if (r_b_half) begin
                r_b_valid <= 1'b0;
                r_b_half  <= 1'b0;
            end else begin
                r_b_half  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_c1   <= pfe_pkg::to_ascii(enc_first);
            r_b_c2   <= pfe_pkg::to_ascii(enc_second);
            r_b_done <= pair_done;
        end
    end

    assign o_out_valid    = r_b_valid;
    assign o_cipher_char  = r_b_half ? r_b_c2 : r_b_c1;
    assign o_last_of_run  = r_b_half;
    assign o_message_done = r_b_half && r_b_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PFE_ASSERT_NEXT(a_second_follows, r_b_valid && !r_b_half && !i_out_stall, o_out_valid && o_last_of_run, "second letter of pair missing")
    `PFE_ASSERT_IMPL(a_done_on_second, o_out_valid && o_message_done, o_last_of_run, "message_done on first letter")
    `PFE_ASSERT_NEXT(a_end_clears, a_move && r_a_end, !r_pend_valid, "pending letter survived message end")
    `PFE_ASSERT_IMPL(a_load_when_free, b_load, b_free, "pair register overwritten")

endmodule
